### rtl/ipv4h_pkg.sv
// Shared types and constants for the IPv4 transmit header builder.
`timescale 1ns / 1ps

package ipv4h_pkg;

	localparam int unsigned MaxFrameBytesDefault = 1500;

	localparam int unsigned HdrWords = 5;
	localparam int unsigned IdxW     = 3;

	localparam logic [15:0] HdrBytes      = 16'd20;
	localparam logic [7:0]  VerIhl        = 8'h45;
	localparam logic [7:0]  Dscp          = 8'h00;
	localparam logic [15:0] FlagsDf       = 16'h4000;
	localparam logic [7:0]  TtlDefault    = 8'd64;
	localparam logic [7:0]  McastFirstOct = 8'd224;
	localparam logic [31:0] BcastAddr     = 32'hFFFF_FFFF;

	localparam logic [IdxW-1:0] WordLen   = 3'd0;
	localparam logic [IdxW-1:0] WordIdent = 3'd1;
	localparam logic [IdxW-1:0] WordCsum  = 3'd2;
	localparam logic [IdxW-1:0] WordSrc   = 3'd3;
	localparam logic [IdxW-1:0] WordDst   = 3'd4;

	typedef struct packed {
		logic [31:0] dest_address;
		logic [7:0]  protocol;
		logic [15:0] payload_length;
	} in_item_t;

	typedef struct packed {
		logic [31:0]     header_word;
		logic [IdxW-1:0] word_index;
		logic            last;
		logic            use_broadcast_mac;
		logic            dropped;
	} out_item_t;

	// Finished header for one request, ready to be sent word by word.
	typedef struct packed {
		logic [HdrWords-1:0][31:0] words;
		logic                      bcast;
		logic                      dropped;
	} hdr_t;

endpackage

### rtl/ipv4h_build.sv
// Header word and checksum generation for one send request.
`timescale 1ns / 1ps

module ipv4h_build #(
	parameter int unsigned MAX_FRAME_BYTES = ipv4h_pkg::MaxFrameBytesDefault
) (
	input  ipv4h_pkg::in_item_t req,
	input  logic [15:0]         ident,
	input  logic [31:0]         source_address,
	output ipv4h_pkg::hdr_t     hdr
);
	import ipv4h_pkg::*;

	localparam logic [16:0] MaxFrame = 17'(MAX_FRAME_BYTES);

	logic [16:0] total_wide;
	logic [15:0] total;
	logic [31:0] w0, w1, w2_pre;
	logic [18:0] acc;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] csum;

	assign total_wide = {1'b0, req.payload_length} + {1'b0, HdrBytes};
	assign total      = total_wide[15:0];

	assign w0     = {VerIhl, Dscp, total};
	assign w1     = {ident, FlagsDf};
	assign w2_pre = {TtlDefault, req.protocol, 16'h0000};

	// Sum the ten halfwords, checksum field taken as zero.
	assign acc = 19'(w0[31:16]) + 19'(w0[15:0])
	           + 19'(w1[31:16]) + 19'(w1[15:0])
	           + 19'(w2_pre[31:16])
	           + 19'(source_address[31:16]) + 19'(source_address[15:0])
	           + 19'(req.dest_address[31:16]) + 19'(req.dest_address[15:0]);

	// Two end-around folds bring the sum into 16 bits.
	assign fold1 = {1'b0, acc[15:0]} + {14'd0, acc[18:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
	assign csum  = ~fold2;

	always_comb begin
		hdr.words[WordLen]   = w0;
		hdr.words[WordIdent] = w1;
		hdr.words[WordCsum]  = {w2_pre[31:16], csum};
		hdr.words[WordSrc]   = source_address;
		hdr.words[WordDst]   = req.dest_address;
		hdr.bcast            = (req.dest_address == BcastAddr)
		                    || (req.dest_address[31:24] >= McastFirstOct);
		hdr.dropped          = total_wide > MaxFrame;
	end

endmodule

### rtl/ipv4_tx_header_builder.sv
// Top level of the IPv4 transmit header builder.
//
// Usage: a send request (destination, protocol, payload length) is a transfer
// on the in channel; each header word is a transfer on the out channel, word 0
// first, last set on word 4. A request whose total length exceeds
// MAX_FRAME_BYTES gives a single result with dropped set and does not consume
// an identification value. The user writes source_address through cfg_wr_en
// and cfg_wr_data while no request is in flight; the block does not enforce it.
// A request passes through the input register and then the header register,
// which is loaded only once the previous header has drained, before its first
// word is offered on the out channel. The single word-wide port gives one
// header word per cycle while out_ready is high, and one result for a dropped
// request. The next request is taken into the input register while the current
// header drains, and its header is built in the cycle the last word leaves.
// Reset clears the identification counter, source address and all valid bits.
// When the receiver stalls, the current word holds and the input register
// fills, after which in_ready drops.
`timescale 1ns / 1ps

module ipv4_tx_header_builder #(
	parameter int unsigned MAX_FRAME_BYTES = ipv4h_pkg::MaxFrameBytesDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ipv4h_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ipv4h_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data
);
	import ipv4h_pkg::*;

	logic            valid_s1;
	in_item_t        req_s1;
	logic            valid_s2;
	hdr_t            hdr_s2;
	logic [IdxW-1:0] idx_s2;
	logic [15:0]     ident_q;
	logic [31:0]     source_q;

	hdr_t        built;
	logic        last_word;
	logic        out_xfer;
	logic        s2_free;
	logic        adv_s1;
	logic [31:0] word_sel;

	ipv4h_build #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_build (
		.req           (req_s1),
		.ident         (ident_q),
		.source_address(source_q),
		.hdr           (built)
	);

	assign last_word = hdr_s2.dropped || (idx_s2 == WordDst);
	assign out_xfer  = valid_s2 && out_ready;
	assign s2_free   = !valid_s2 || (out_xfer && last_word);
	assign adv_s1    = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || s2_free;

	always_comb begin
		case (idx_s2)
			WordLen:   word_sel = hdr_s2.words[WordLen];
			WordIdent: word_sel = hdr_s2.words[WordIdent];
			WordCsum:  word_sel = hdr_s2.words[WordCsum];
			WordSrc:   word_sel = hdr_s2.words[WordSrc];
			WordDst:   word_sel = hdr_s2.words[WordDst];
			default:   word_sel = '0;
		endcase
		out_data.header_word       = hdr_s2.dropped ? 32'd0 : word_sel;
		out_data.word_index        = idx_s2;
		out_data.last              = last_word;
		out_data.use_broadcast_mac = hdr_s2.bcast;
		out_data.dropped           = hdr_s2.dropped;
	end

	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
			ident_q  <= '0;
			source_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				idx_s2   <= WordLen;
			end else if (out_xfer) begin
				// advance to the next word, or empty the stage after the last
				if (last_word) begin
					valid_s2 <= 1'b0;
				end else begin
					idx_s2 <= idx_s2 + 3'd1;
				end
			end
			if (adv_s1 && !built.dropped) begin
				ident_q <= ident_q + 16'd1;
			end
			if (cfg_wr_en) begin
				source_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (adv_s1) begin
			hdr_s2 <= built;
		end
	end

endmodule

### verif/ipv4h_header_checker.sv
// Checker for the IPv4 transmit header builder: predicts header words and compares transfers.
`timescale 1ns / 1ps

module ipv4h_header_checker #(
	parameter int unsigned MAX_FRAME_BYTES = ipv4h_pkg::MaxFrameBytesDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ipv4h_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ipv4h_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	output int                   mismatches,
	output int                   pending
);

	import ipv4h_pkg::*;

	out_item_t   header_q[$];
	logic [31:0] own_addr;
	logic [15:0] next_ident;
	int          fail_cnt;

	task automatic predict_header(input in_item_t req);
		logic [HdrWords-1:0][31:0] w;
		logic [31:0]               sum;
		logic                      bcast;
		out_item_t                 res;
		bcast = (req.dest_address == BcastAddr) || (req.dest_address[31:24] >= McastFirstOct);
		res.use_broadcast_mac = bcast;
		if ({16'd0, req.payload_length} + {16'd0, HdrBytes} > MAX_FRAME_BYTES) begin
			res.header_word = '0;
			res.word_index  = WordLen;
			res.last        = 1'b1;
			res.dropped     = 1'b1;
			header_q.push_back(res);
			return;
		end
		w[WordLen]   = {VerIhl, Dscp, req.payload_length + HdrBytes};
		w[WordIdent] = {next_ident, FlagsDf};
		w[WordCsum]  = {TtlDefault, req.protocol, 16'd0};
		w[WordSrc]   = own_addr;
		w[WordDst]   = req.dest_address;
		sum = '0;
		for (int k = 0; k < HdrWords; k++)
			sum = sum + w[k][31:16] + w[k][15:0];
		// fold carries back in until the sum fits in a halfword
		while (sum[31:16] != 16'd0)
			sum = sum[15:0] + sum[31:16];
		w[WordCsum][15:0] = ~sum[15:0];
		next_ident = next_ident + 16'd1;
		res.dropped = 1'b0;
		for (int k = 0; k < HdrWords; k++) begin
			res.header_word = w[k];
			res.word_index  = IdxW'(k);
			res.last        = (res.word_index == WordDst);
			header_q.push_back(res);
		end
	endtask

	task automatic check_word(input out_item_t got);
		out_item_t want;
		if (header_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("%0t: unexpected header transfer word %h idx %0d last %b bcast %b drop %b",
					$realtime, got.header_word, got.word_index, got.last,
					got.use_broadcast_mac, got.dropped);
			return;
		end
		want = header_q.pop_front();
		if (got.header_word !== want.header_word || got.word_index !== want.word_index ||
		    got.last !== want.last || got.use_broadcast_mac !== want.use_broadcast_mac ||
		    got.dropped !== want.dropped) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("%0t: mismatch got word %h idx %0d last %b bcast %b drop %b, %s %h %0d %b %b %b",
					$realtime, got.header_word, got.word_index, got.last,
					got.use_broadcast_mac, got.dropped, "expected",
					want.header_word, want.word_index, want.last,
					want.use_broadcast_mac, want.dropped);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q.delete();
			own_addr   = '0;
			next_ident = '0;
			fail_cnt   = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en)
				own_addr = cfg_wr_data;
			// an output transfer never belongs to a request taken at the same edge
			if (out_valid && out_ready)
				check_word(out_data);
			if (in_valid && in_ready)
				predict_header(in_data);
			mismatches <= fail_cnt;
			pending    <= header_q.size();
		end
	end

endmodule

### verif/tb_ipv4_tx_header_builder.sv
// Testbench top for the IPv4 transmit header builder: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_ipv4_tx_header_builder;

	import ipv4h_pkg::*;

	localparam int unsigned MaxFrame   = MaxFrameBytesDefault;
	localparam logic [15:0] MaxPayload = 16'(MaxFrame) - HdrBytes;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	int          mismatches;
	int          pending;
	int          burst_left;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	int          rx_tick = 0;

	ipv4_tx_header_builder #(
		.MAX_FRAME_BYTES(MaxFrame)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	ipv4h_header_checker #(
		.MAX_FRAME_BYTES(MaxFrame)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: switch between open, random, sparse and periodic stall patterns
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(8, 80);
		end else
			rx_left <= rx_left - 1;
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: out_ready <= (rx_tick % 4) != 3;
			default:     out_ready <= 1'b1;
		endcase
	end

	// hold valid and payload until the transfer; open a gap between bursts
	task automatic send_request(input in_item_t item);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		burst_left--;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_fields(input logic [31:0] dest, input logic [7:0] proto,
	                           input logic [15:0] len);
		in_item_t item;
		item.dest_address   = dest;
		item.protocol       = proto;
		item.payload_length = len;
		send_request(item);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_source(input logic [31:0] addr);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic in_item_t random_request();
		in_item_t    item;
		logic [31:0] rnd;
		logic [7:0]  octet;
		rnd   = $urandom;
		octet = 8'($urandom_range(224, 255));
		item.protocol = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0:       item.dest_address = BcastAddr;
			1:       item.dest_address = {octet, rnd[23:0]};
			2:       item.dest_address = {McastFirstOct - 8'd1, rnd[23:0]};
			default: item.dest_address = rnd;
		endcase
		case ($urandom_range(0, 9))
			0:       item.payload_length = MaxPayload;
			1:       item.payload_length = MaxPayload + 16'd1;
			2:       item.payload_length = 16'($urandom_range(MaxPayload + 1, 65535));
			3:       item.payload_length = 16'($urandom_range(0, 31));
			default: item.payload_length = 16'($urandom_range(0, MaxPayload));
		endcase
		return item;
	endfunction

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		burst_left  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, source address still at its reset value
		send_fields(32'h0000_0000, 8'h00, 16'd0);
		send_fields(32'hFFFF_FFFF, 8'hFF, MaxPayload);
		send_fields(32'hE000_0000, 8'h06, MaxPayload + 16'd1);
		send_fields(32'hDFFF_FFFF, 8'h11, 16'hFFFF);
		send_fields(32'hFFFF_FFFE, 8'h01, 16'd20);
		send_fields(32'h7FFF_FFFF, 8'h80, MaxPayload - 16'd1);
		send_fields(32'h8000_0000, 8'h7F, 16'd1);
		send_fields(32'h0A00_0001, 8'h06, 16'h5555);
		send_fields(32'hC0A8_0001, 8'h11, 16'h02AA);
		send_fields(32'hEFFF_FFFF, 8'h55, 16'h0155);
		send_fields(32'h0000_0000, 8'hAA, 16'h8000);
		send_fields(32'hFFFF_FFFF, 8'h00, 16'hFFFF);
		send_fields(32'h0102_0304, 8'h2F, 16'(MaxFrame));
		send_fields(32'h5555_5555, 8'h33, 16'h0400);

		write_source(32'hFFFF_FFFF);
		send_fields(32'hFFFF_FFFF, 8'hFF, MaxPayload);
		send_fields(32'h0000_0000, 8'h00, 16'd0);
		send_fields(32'hAAAA_AAAA, 8'hCC, 16'h0333);
		send_fields(32'hF000_0001, 8'h06, MaxPayload + 16'd1);

		write_source($urandom);
		repeat (54) send_request(random_request());

		write_source(32'h0000_0000);
		repeat (54) send_request(random_request());

		write_source(32'hC0A8_0A01);
		repeat (54) send_request(random_request());

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

### ipv4_tx_header_builder.f
rtl/ipv4h_pkg.sv
rtl/ipv4h_build.sv
rtl/ipv4_tx_header_builder.sv
verif/ipv4h_header_checker.sv
verif/tb_ipv4_tx_header_builder.sv
